FILE: rtl/bcdts_pkg.sv
// Package with event codes, edit modes, field masks and the BCD adjust function.
`timescale 1ns / 1ps

package bcdts_pkg;

  // Button event codes carried in the input item.
  localparam logic [1:0] FUNC_NONE  = 2'd0;
  localparam logic [1:0] FUNC_SET   = 2'd1;
  localparam logic [1:0] FUNC_MINUS = 2'd2;
  localparam logic [1:0] FUNC_PLUS  = 2'd3;

  // Edit modes, which also select the field under edit.
  localparam logic [2:0] MODE_CLOCK   = 3'd0;
  localparam logic [2:0] MODE_HOURS   = 3'd1;
  localparam logic [2:0] MODE_MINUTES = 3'd2;
  localparam logic [2:0] MODE_WEEKDAY = 3'd3;
  localparam logic [2:0] MODE_DAY     = 3'd4;
  localparam logic [2:0] MODE_MONTH   = 3'd5;
  localparam logic [2:0] MODE_YEAR    = 3'd6;

  // Reset value of the idle timeout register.
  localparam logic [7:0] TIMEOUT_RESET = 8'd5;

  // Addends for BCD decrement and increment.
  localparam logic [7:0] BCD_DEC_ADDEND = 8'h99;
  localparam logic [7:0] BCD_INC_ADDEND = 8'h01;

  // Field limits in BCD (weekday is binary).
  localparam logic [7:0] HOURS_MAX   = 8'h23;
  localparam logic [7:0] MINUTES_MAX = 8'h59;
  localparam logic [2:0] WEEKDAY_MAX = 3'd6;
  localparam logic [7:0] DAY_MAX     = 8'h31;
  localparam logic [7:0] MONTH_MAX   = 8'h12;
  localparam logic [7:0] YEAR_MAX    = 8'h99;
  localparam logic [7:0] BCD_ONE     = 8'h01;

  // Masked input item held in the input register.
  typedef struct packed {
    logic [1:0] func;
    logic [6:0] seconds;
    logic [6:0] minutes;
    logic [5:0] hours;
    logic [5:0] day;
    logic [2:0] weekday;
    logic [4:0] month;
    logic [7:0] year;
  } in_item_t;

  // Binary add followed by a decimal adjust, as an 8-bit accumulator does it.
  function automatic logic [7:0] add_daa(input logic [7:0] val, input logic [7:0] addend);
    logic [8:0] sum;
    logic [4:0] nib_sum;
    logic       cy;
    logic       ac;
    logic [7:0] a;
    logic [3:0] lo;
    logic [3:0] hi;
    logic [7:0] corr;
    sum     = {1'b0, val} + {1'b0, addend};
    nib_sum = {1'b0, val[3:0]} + {1'b0, addend[3:0]};
    cy      = sum[8];
    ac      = nib_sum[4];
    a       = sum[7:0];
    lo      = a[3:0];
    hi      = a[7:4];
    corr    = 8'h00;
    if (ac || (lo > 4'd9)) begin
      corr = corr + 8'h06;
    end
    if (cy || (hi > 4'd9) || ((hi >= 4'd9) && (lo > 4'd9))) begin
      corr = corr + 8'h60;
    end
    return a + corr;
  endfunction

endpackage

FILE: rtl/bcd_clock_time_set_controller_core.sv
// Top level of the BCD clock time-set controller: input register, edit logic, result register.
`timescale 1ns / 1ps

//  Channel   Direction  Payload
//  s_axis    in         tuser: func; tdata: seven raw clock bytes
//  m_axis    out        tuser: edit_mode, write_time; tdata: six edited time fields
//  cfg       in         idle_timeout_seconds, written when cfg_we_i is high
//
//  One item enters per cycle while the output is not stalled; each item passes through
//  the input register and the result register around the edit logic.
//  The mode, seconds tracking and press time update as an item moves into the
//  result register, so back-to-back items see each other's effects in order.
//  A stalled output holds its item; the input register keeps filling until both are full.
//  Reset clears the mode, counters, valid flags and loads the timeout with 5.

module bcd_clock_time_set_controller_core
  import bcdts_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write: idle_timeout_seconds.
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  // Input items.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: raw_seconds[7:0], raw_minutes[15:8], raw_hours[23:16], raw_day[31:24],
  //        raw_weekday[39:32], raw_month[47:40], raw_year[55:48]
  input  logic [55:0] s_axis_tdata,
  // tuser: func[1:0]
  input  logic [1:0]  s_axis_tuser,
  // Result items.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: out_hours[5:0], out_minutes[12:6], out_weekday[15:13], out_day[21:16],
  //        out_month[26:22], out_year[34:27], zero[39:35]
  output logic [39:0] m_axis_tdata,
  // tuser: edit_mode[2:0], write_time[3]
  output logic [3:0]  m_axis_tuser
);

  logic        in_valid_q;
  in_item_t    in_item_q;
  in_item_t    in_item_d;
  logic        out_valid_q;
  logic [39:0] out_data_q;
  logic [39:0] out_data_d;
  logic [3:0]  out_user_q;
  logic [3:0]  out_user_d;

  logic [7:0]  timeout_q;
  logic [2:0]  mode_q;
  logic [2:0]  mode_d;
  logic [6:0]  last_sec_q;
  logic [31:0] sec_count_q;
  logic [31:0] sec_count_d;
  logic [31:0] press_count_q;
  logic [31:0] press_count_d;

  logic        out_free;
  logic        advance;
  logic        in_take;

  logic [7:0]  hrs_w;
  logic [7:0]  mins_w;
  logic [2:0]  wday_w;
  logic [7:0]  day_w;
  logic [7:0]  mon_w;
  logic [7:0]  year_w;
  logic        write_w;
  logic        pressed;
  logic [31:0] idle_span;

  // Handshake: the result register frees when taken, the input register when it advances.
  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  // Mask the raw bytes into their BCD fields on the way into the input register.
  always_comb begin
    in_item_d.func    = s_axis_tuser;
    in_item_d.seconds = s_axis_tdata[6:0];
    in_item_d.minutes = s_axis_tdata[14:8];
    in_item_d.hours   = s_axis_tdata[21:16];
    in_item_d.day     = s_axis_tdata[29:24];
    in_item_d.weekday = s_axis_tdata[34:32];
    in_item_d.month   = s_axis_tdata[44:40];
    in_item_d.year    = s_axis_tdata[55:48];
  end

  // Edit logic: count the second, handle the event, then check the idle timeout.
  always_comb begin
    hrs_w   = {2'b00, in_item_q.hours};
    mins_w  = {1'b0, in_item_q.minutes};
    wday_w  = in_item_q.weekday;
    day_w   = {2'b00, in_item_q.day};
    mon_w   = {3'b000, in_item_q.month};
    year_w  = in_item_q.year;
    write_w = 1'b0;
    pressed = 1'b0;
    mode_d  = mode_q;

    sec_count_d = sec_count_q;
    if (last_sec_q != in_item_q.seconds) begin
      sec_count_d = sec_count_q + 32'd1;
    end

    if (in_item_q.func == FUNC_SET) begin
      pressed = 1'b1;
      if (mode_q == MODE_CLOCK) begin
        mode_d = MODE_HOURS;
      end else if (mode_q >= MODE_YEAR) begin
        mode_d = MODE_HOURS;
      end else begin
        mode_d = mode_q + 3'd1;
      end
    end else if ((in_item_q.func == FUNC_MINUS) && (mode_q != MODE_CLOCK)) begin
      pressed = 1'b1;
      write_w = 1'b1;
      case (mode_q)
        MODE_HOURS: begin
          hrs_w = (hrs_w > 8'h00) ? add_daa(hrs_w, BCD_DEC_ADDEND) : HOURS_MAX;
        end
        MODE_MINUTES: begin
          mins_w = (mins_w > 8'h00) ? add_daa(mins_w, BCD_DEC_ADDEND) : MINUTES_MAX;
        end
        MODE_WEEKDAY: begin
          wday_w = (wday_w > 3'd0) ? (wday_w - 3'd1) : WEEKDAY_MAX;
        end
        MODE_DAY: begin
          day_w = (day_w > BCD_ONE) ? add_daa(day_w, BCD_DEC_ADDEND) : DAY_MAX;
        end
        MODE_MONTH: begin
          mon_w = (mon_w > BCD_ONE) ? add_daa(mon_w, BCD_DEC_ADDEND) : MONTH_MAX;
        end
        default: begin
          year_w = (year_w > BCD_ONE) ? add_daa(year_w, BCD_DEC_ADDEND) : YEAR_MAX;
        end
      endcase
    end else if ((in_item_q.func == FUNC_PLUS) && (mode_q != MODE_CLOCK)) begin
      pressed = 1'b1;
      write_w = 1'b1;
      case (mode_q)
        MODE_HOURS: begin
          hrs_w = (hrs_w < HOURS_MAX) ? add_daa(hrs_w, BCD_INC_ADDEND) : 8'h00;
        end
        MODE_MINUTES: begin
          mins_w = (mins_w < MINUTES_MAX) ? add_daa(mins_w, BCD_INC_ADDEND) : 8'h00;
        end
        MODE_WEEKDAY: begin
          wday_w = (wday_w < WEEKDAY_MAX) ? (wday_w + 3'd1) : 3'd0;
        end
        MODE_DAY: begin
          day_w = (day_w < DAY_MAX) ? add_daa(day_w, BCD_INC_ADDEND) : BCD_ONE;
        end
        MODE_MONTH: begin
          mon_w = (mon_w < MONTH_MAX) ? add_daa(mon_w, BCD_INC_ADDEND) : BCD_ONE;
        end
        default: begin
          year_w = (year_w < YEAR_MAX) ? add_daa(year_w, BCD_INC_ADDEND) : BCD_ONE;
        end
      endcase
    end

    // Every press records the current second count.
    press_count_d = pressed ? sec_count_d : press_count_q;

    // Leave edit mode once the idle span exceeds the timeout (modulo 2^32).
    idle_span = sec_count_d - press_count_d;
    if (idle_span > {24'd0, timeout_q}) begin
      mode_d = MODE_CLOCK;
    end
  end

  // Pack the result item.
  assign out_data_d = {5'd0, year_w, mon_w[4:0], day_w[5:0], wday_w, mins_w[6:0], hrs_w[5:0]};
  assign out_user_d = {write_w, mode_d};

  // Control state, counters and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      timeout_q     <= TIMEOUT_RESET;
      mode_q        <= MODE_CLOCK;
      last_sec_q    <= 7'd0;
      sec_count_q   <= 32'd0;
      press_count_q <= 32'd0;
    end else begin
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (advance) begin
        mode_q        <= mode_d;
        last_sec_q    <= in_item_q.seconds;
        sec_count_q   <= sec_count_d;
        press_count_q <= press_count_d;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q <= in_item_d;
    end
    if (advance) begin
      out_data_q <= out_data_d;
      out_user_q <= out_user_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule
